// ===== hdl/cfb_pkg.sv =====
// Shared types, constants and CRC-8 functions for the command frame builder.
// Used by cfb_out_queue and crc8_command_frame_builder; depends on nothing.
package cfb_pkg;

  localparam int ENTRY_COUNT = 5;
  localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

  localparam logic [7:0] MAX_PAYLOAD   = 8'd253;
  localparam logic [7:0] LEN_OVERHEAD  = 8'd2;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] CRC_INIT      = 8'hFF;
  localparam logic [7:0] CRC_ZERO      = 8'h00;
  localparam logic [7:0] CRC_ZERO_SUB  = 8'h01;
  localparam logic [7:0] CRC_ONES_SUB  = 8'hFE;

  localparam logic [7:0] START_CODE_RST = 8'h02;
  localparam logic [7:0] END_CODE_RST   = 8'h03;

  localparam logic [0:0] CFG_START_CODE = 1'b0;
  localparam logic [0:0] CFG_END_CODE   = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
  } entry_t;

  typedef struct packed {
    logic   valid;
    cnt_t   count;
    entry_t [ENTRY_COUNT-1:0] entries;
  } load_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  function automatic logic [7:0] crc_final(input logic [7:0] crc);
    logic [7:0] r;
    r = crc;
    if (crc == CRC_ZERO) begin
      r = CRC_ZERO_SUB;
    end else if (crc == CRC_INIT) begin
      r = CRC_ONES_SUB;
    end
    return r;
  endfunction

endpackage

// ===== hdl/cfb_out_queue.sv =====
// Result buffer and serializer: holds the bytes produced by one input transfer
// and sends them one per cycle while out_tready is high. Depends on cfb_pkg.
module cfb_out_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  cfb_pkg::load_t  load,
  output logic            space,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // out_byte
  output logic            out_tuser,  // frame_end
  output logic            out_tlast   // run_last
);

  cfb_pkg::entry_t [cfb_pkg::ENTRY_COUNT-1:0] q_r, q_nxt;
  cfb_pkg::cnt_t cnt_r, cnt_nxt;
  logic pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign space      = (cnt_r == '0) || ((cnt_r == cfb_pkg::cnt_t'(1)) && out_tready);
  assign out_tdata  = q_r[0].data;
  assign out_tuser  = q_r[0].frame_end;
  assign out_tlast  = (cnt_r == cfb_pkg::cnt_t'(1));

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load.valid) begin
      q_nxt   = load.entries;
      cnt_nxt = load.count;
    end else if (pop) begin
      for (int i = 0; i < cfb_pkg::ENTRY_COUNT - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_nxt = cnt_r - cfb_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cfb_pkg::cnt_t'(cfb_pkg::ENTRY_COUNT))
    else $error("result count out of range");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load.valid |-> space)
    else $error("results loaded while the buffer still holds pending bytes");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load.valid) |=> (cnt_r == $past(cnt_r) - cfb_pkg::cnt_t'(1)))
    else $error("count did not drop after an output transfer");

endmodule

// ===== hdl/crc8_command_frame_builder.sv =====
// Top level of the CRC-8 command frame builder: frame state, CRC and codes.
// Depends on cfb_pkg and cfb_out_queue.
//
//  Port group  Dir  tdata / tuser contents (low bit up)
//  in_*        in   tdata: data_byte[7:0], payload_count[15:8]; tuser: starts_frame
//  out_*       out  tdata: out_byte[7:0]; tuser: frame_end; tlast: run_last
//  cfg_*       in   write: cfg_addr 0 start_code, 1 end_code; cfg_wdata 8 bits
//
// An input transfer is processed in its accept cycle and its results (0 to 5 bytes)
// are loaded into the output buffer and leave from the next cycle on, one per ready cycle.
// A new input is taken while the last buffered byte is being sent, so a payload stream
// runs at one byte per cycle unstalled; a command or close loads 3 bytes, 5 if empty.
// Reset is synchronous: clears frame state and output buffer, presets CRC and codes.
// A stall on the output holds the buffer and deasserts in_tready while it holds more
// than one byte, or one byte that is not taken.
module crc8_command_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_byte, payload_count
  input  logic        in_tuser,   // starts_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tuser,  // frame_end
  output logic        out_tlast,  // run_last
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] start_code_r, end_code_r;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] left_r, left_nxt;
  logic       in_frame_r, in_frame_nxt;

  logic       accept;
  logic [7:0] data_byte, count_in, count_sat, len, crc_cmd, crc_pay, left_dec;
  cfb_pkg::load_t load;

  assign accept    = in_tvalid && in_tready;
  assign data_byte = in_tdata[7:0];
  assign count_in  = in_tdata[15:8];
  assign count_sat = (count_in > cfb_pkg::MAX_PAYLOAD) ? cfb_pkg::MAX_PAYLOAD : count_in;
  assign len       = count_sat + cfb_pkg::LEN_OVERHEAD;
  assign crc_cmd   = cfb_pkg::crc_feed(cfb_pkg::crc_feed(cfb_pkg::CRC_INIT, len), data_byte);
  assign crc_pay   = cfb_pkg::crc_feed(crc_r, data_byte);
  assign left_dec  = (left_r != 8'd0) ? (left_r - 8'd1) : 8'd0;

  always_comb begin
    load         = '0;
    crc_nxt      = crc_r;
    left_nxt     = left_r;
    in_frame_nxt = in_frame_r;
    load.valid   = accept;
    if (accept) begin
      if (in_tuser) begin
        load.entries[0].data = start_code_r;
        load.entries[1].data = len;
        load.entries[2].data = data_byte;
        if (count_sat == 8'd0) begin
          load.entries[3].data      = cfb_pkg::crc_final(crc_cmd);
          load.entries[4].data      = end_code_r;
          load.entries[4].frame_end = 1'b1;
          load.count                = cfb_pkg::cnt_t'(5);
          crc_nxt                   = cfb_pkg::CRC_INIT;
          left_nxt                  = 8'd0;
          in_frame_nxt              = 1'b0;
        end else begin
          load.count   = cfb_pkg::cnt_t'(3);
          crc_nxt      = crc_cmd;
          left_nxt     = count_sat;
          in_frame_nxt = 1'b1;
        end
      end else if (in_frame_r) begin
        load.entries[0].data = data_byte;
        if (left_dec == 8'd0) begin
          load.entries[1].data      = cfb_pkg::crc_final(crc_pay);
          load.entries[2].data      = end_code_r;
          load.entries[2].frame_end = 1'b1;
          load.count                = cfb_pkg::cnt_t'(3);
          crc_nxt                   = cfb_pkg::CRC_INIT;
          left_nxt                  = 8'd0;
          in_frame_nxt              = 1'b0;
        end else begin
          load.count = cfb_pkg::cnt_t'(1);
          crc_nxt    = crc_pay;
          left_nxt   = left_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= cfb_pkg::START_CODE_RST;
      end_code_r   <= cfb_pkg::END_CODE_RST;
      crc_r        <= cfb_pkg::CRC_INIT;
      left_r       <= 8'd0;
      in_frame_r   <= 1'b0;
    end else begin
      crc_r      <= crc_nxt;
      left_r     <= left_nxt;
      in_frame_r <= in_frame_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          cfb_pkg::CFG_START_CODE: start_code_r <= cfg_wdata;
          cfb_pkg::CFG_END_CODE:   end_code_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  cfb_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .space      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_open_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (left_r != 8'd0))
    else $error("open frame with no payload bytes left");

  a_closed_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (left_r == 8'd0 && crc_r == cfb_pkg::CRC_INIT))
    else $error("closed frame left stale state");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= cfb_pkg::MAX_PAYLOAD)
    else $error("payload counter above maximum");

endmodule
